/* hdl/ucdw_pkg.sv */
package ucdw_pkg;

  // Default walk limit in bytes.
  localparam int unsigned MAX_CONFIG_BYTES_DEF = 255;

  // Stream positions with a fixed meaning.
  localparam int unsigned POS_TOTAL_LOW  = 2;
  localparam int unsigned POS_TOTAL_HIGH = 3;
  localparam int unsigned POS_LIMIT_LIVE = 4;
  localparam int unsigned POS_CONFIG     = 5;

  // Descriptor type codes.
  localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'h05;

  // Boot mouse interface triple.
  localparam logic [7:0] HID_CLASS      = 8'h03;
  localparam logic [7:0] BOOT_SUBCLASS  = 8'h01;
  localparam logic [7:0] MOUSE_PROTOCOL = 8'h02;

  // Endpoint address and attribute decoding.
  localparam logic [7:0] EP_DIR_IN      = 8'h80;
  localparam logic [7:0] EP_NUM_MASK    = 8'h0F;
  localparam logic [7:0] XFER_TYPE_MASK = 8'h03;
  localparam logic [7:0] XFER_INTERRUPT = 8'h03;

  typedef enum logic [1:0] {
    CAUSE_FOUND        = 2'd0,
    CAUSE_ZERO_LENGTH  = 2'd1,
    CAUSE_LENGTH_LIMIT = 2'd2,
    CAUSE_STREAM_END   = 2'd3
  } stop_cause_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  endpoint_number;
    logic [15:0] max_packet_size;
    logic [7:0]  poll_interval;
    logic [7:0]  config_value;
    stop_cause_t stop_cause;
  } result_t;

endpackage

/* hdl/usb_config_descriptor_walker_unit.sv */
// Channel  Handshake           Payload
// input    in_valid/in_ready   data_byte, last
// output   out_valid/out_ready found, endpoint_number, max_packet_size,
//                              poll_interval, config_value, stop_cause
//
// One byte per cycle while no held result stalls: a byte waits in the input
// register, then the walker logic decides it and loads the result register
// in the same cycle. The result is loaded as the byte ending the walk leaves
// the input register. Reset is synchronous; no clearing pass follows it.
// A held result stalls the input register only while out_ready is low.
module usb_config_descriptor_walker_unit #(
  parameter int unsigned MAX_CONFIG_BYTES = ucdw_pkg::MAX_CONFIG_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [3:0]  endpoint_number,
  output logic [15:0] max_packet_size,
  output logic [7:0]  poll_interval,
  output logic [7:0]  config_value,
  output logic [1:0]  stop_cause
);
  import ucdw_pkg::*;

  logic    in_full;
  item_t   in_item;
  logic    advance;
  logic    emit;
  result_t step_result;
  result_t res;

  // The held byte moves on whenever the result register can take a result.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item <= '{data_byte: data_byte, last: last};
    end
  end

  ucdw_core #(
    .MAX_CONFIG_BYTES(MAX_CONFIG_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .emit   (emit),
    .result (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= step_result;
    end
  end

  assign found           = res.found;
  assign endpoint_number = res.endpoint_number;
  assign max_packet_size = res.max_packet_size;
  assign poll_interval   = res.poll_interval;
  assign config_value    = res.config_value;
  assign stop_cause      = res.stop_cause;

  // A found endpoint always reports the found cause, and only then.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (stop_cause == CAUSE_FOUND)))
    else $error("found flag and stop cause disagree");

  // Endpoint fields are zero unless an endpoint was found.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |->
      (endpoint_number == 4'd0 && max_packet_size == 16'd0 && poll_interval == 8'd0))
    else $error("endpoint fields set without a found endpoint");

  // A held byte that cannot move stays in the input register.
  assert property (@(posedge clk) disable iff (rst) (in_full && !advance) |=> in_full)
    else $error("input byte lost while stalled");

endmodule

/* hdl/ucdw_core.sv */
module ucdw_core #(
  parameter int unsigned MAX_CONFIG_BYTES = ucdw_pkg::MAX_CONFIG_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ucdw_pkg::item_t   item,
  output logic              emit,
  output ucdw_pkg::result_t result
);
  import ucdw_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CONFIG_BYTES + 1);
  localparam logic [CW-1:0] LIMIT_MAX = CW'(MAX_CONFIG_BYTES);

  // Walk state.
  logic [CW-1:0] byte_count;
  logic [CW-1:0] length_limit;
  logic [CW-1:0] desc_start;
  logic [7:0]    descriptor_offset;
  logic [7:0]    descriptor_length;
  logic [7:0]    descriptor_kind;
  logic [7:0]    field_bytes [6];
  logic [7:0]    total_low;
  logic [7:0]    configuration_byte;
  logic          mouse_interface_armed;
  logic          walk_done;

  // Values seen by the current byte, including its own write.
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] limit_eff;
  logic [CW-1:0] start_eff;
  logic [7:0]    len_eff;
  logic [7:0]    kind_eff;
  logic [7:0]    fields_eff [6];
  logic [7:0]    raw_field [8];
  logic [7:0]    fv [8];
  logic [15:0]   total;
  logic [8:0]    offset_inc;
  logic          desc_start_byte;
  logic          zero_stop;
  logic          desc_end;
  logic          limit_hit;
  logic          late;
  logic          judge;
  logic          mouse_match;
  logic          found;
  logic [7:0]    config_eff;

  // Limit, position and the descriptor under construction.
  always_comb begin
    cnt_next        = byte_count + 1'b1;
    total           = {item.data_byte, total_low};
    desc_start_byte = (descriptor_offset == 8'd0);
    if (byte_count == CW'(POS_TOTAL_HIGH)) begin
      limit_eff = (total < 16'(MAX_CONFIG_BYTES)) ? CW'(total) : LIMIT_MAX;
    end else begin
      limit_eff = length_limit;
    end
    start_eff  = desc_start_byte ? byte_count : desc_start;
    len_eff    = desc_start_byte ? item.data_byte : descriptor_length;
    kind_eff   = desc_start_byte ? 8'd0 :
                 (descriptor_offset == 8'd1) ? item.data_byte : descriptor_kind;
    for (int i = 0; i < 6; i++) begin
      if (desc_start_byte) begin
        fields_eff[i] = 8'd0;
      end else if (descriptor_offset == 8'(i + 2)) begin
        fields_eff[i] = item.data_byte;
      end else begin
        fields_eff[i] = field_bytes[i];
      end
    end
    config_eff = (byte_count == CW'(POS_CONFIG)) ? item.data_byte : configuration_byte;
  end

  // Descriptor bytes as the judge sees them: bytes beyond the descriptor's
  // length or at or past the walk limit read as zero.
  always_comb begin
    late         = (cnt_next >= CW'(POS_LIMIT_LIVE));
    raw_field[0] = 8'd0;
    raw_field[1] = kind_eff;
    for (int i = 0; i < 6; i++) begin
      raw_field[i + 2] = fields_eff[i];
    end
    fv[0] = 8'd0;
    for (int k = 1; k < 8; k++) begin
      if (8'(k) >= len_eff) begin
        fv[k] = 8'd0;
      end else if (late && (({1'b0, start_eff} + (CW + 1)'(k)) >= {1'b0, limit_eff})) begin
        fv[k] = 8'd0;
      end else begin
        fv[k] = raw_field[k];
      end
    end
  end

  // Stop conditions and the descriptor decision.
  always_comb begin
    zero_stop   = desc_start_byte && (item.data_byte == 8'd0);
    offset_inc  = {1'b0, descriptor_offset} + 9'd1;
    desc_end    = (offset_inc >= {1'b0, len_eff});
    limit_hit   = late && (cnt_next >= limit_eff);
    judge       = !zero_stop && (desc_end || limit_hit || item.last);
    mouse_match = (fv[5] == HID_CLASS) && (fv[6] == BOOT_SUBCLASS) &&
                  (fv[7] == MOUSE_PROTOCOL);
    found       = judge && (fv[1] == DESC_TYPE_ENDPOINT) && mouse_interface_armed &&
                  ((fv[2] & EP_DIR_IN) != 8'd0) &&
                  ((fv[3] & XFER_TYPE_MASK) == XFER_INTERRUPT);
    emit        = step && !walk_done && (found || zero_stop || limit_hit || item.last);

    result.found           = found;
    result.endpoint_number = found ? 4'(fv[2] & EP_NUM_MASK) : 4'd0;
    result.max_packet_size = found ? {fv[5], fv[4]} : 16'd0;
    result.poll_interval   = found ? fv[6] : 8'd0;
    result.config_value    = config_eff;
    if (found) begin
      result.stop_cause = CAUSE_FOUND;
    end else if (zero_stop) begin
      result.stop_cause = CAUSE_ZERO_LENGTH;
    end else if (limit_hit) begin
      result.stop_cause = CAUSE_LENGTH_LIMIT;
    end else begin
      result.stop_cause = CAUSE_STREAM_END;
    end
  end

  // State update; a marked last byte always returns the walker to reset.
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      byte_count            <= '0;
      length_limit          <= LIMIT_MAX;
      desc_start            <= '0;
      descriptor_offset     <= 8'd0;
      descriptor_length     <= 8'd0;
      descriptor_kind       <= 8'd0;
      total_low             <= 8'd0;
      configuration_byte    <= 8'd0;
      mouse_interface_armed <= 1'b0;
      walk_done             <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        field_bytes[i] <= 8'd0;
      end
    end else if (step && !walk_done) begin
      byte_count         <= cnt_next;
      length_limit       <= limit_eff;
      desc_start         <= start_eff;
      descriptor_length  <= len_eff;
      descriptor_kind    <= kind_eff;
      configuration_byte <= config_eff;
      field_bytes        <= fields_eff;
      if (byte_count == CW'(POS_TOTAL_LOW)) begin
        total_low <= item.data_byte;
      end
      if (!zero_stop) begin
        descriptor_offset <= desc_end ? 8'd0 : offset_inc[7:0];
      end
      if (judge && (fv[1] == DESC_TYPE_INTERFACE)) begin
        mouse_interface_armed <= mouse_match;
      end
      walk_done <= emit;
    end
  end

  // A finished walk stays silent until the stream ends.
  assert property (@(posedge clk) disable iff (rst) (step && walk_done) |-> !emit)
    else $error("result emitted after the walk had finished");

  // A marked last byte rearms the walker for a new stream.
  assert property (@(posedge clk) disable iff (rst)
    (step && item.last) |=> (byte_count == '0 && !walk_done && !mouse_interface_armed))
    else $error("walker not rearmed after the last byte");

  // The byte counter never passes the walk limit.
  assert property (@(posedge clk) disable iff (rst) byte_count <= LIMIT_MAX)
    else $error("byte counter beyond the walk limit");

endmodule
